[design/swcd_pkg.sv]
// Package for the serial wheel command driver: beat types, codes and reset values.
package swcd_pkg;

	// Input beat: a received byte or a millisecond tick.
	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} cmd_in_t;

	// Output beat: the drive outputs after one input beat has been handled.
	typedef struct packed {
		logic [7:0] left_duty;
		logic [7:0] right_duty;
		logic       left_reverse;
		logic       right_reverse;
		logic       link_alive;
	} drv_out_t;

	typedef enum logic [1:0] {
		PH_BLANKS = 2'd0,
		PH_SIGNED = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REV_PAUSE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 3'd4;

	localparam logic [15:0] TIMEOUT_RST    = 16'd500;
	localparam logic [15:0] REV_PAUSE_RST  = 16'd100;
	localparam logic [7:0]  END_MARKER_RST = 8'd10;
	localparam logic [7:0]  OUT_MIN_RST    = 8'd30;
	localparam logic [7:0]  OUT_MAX_RST    = 8'd200;

	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;

	localparam logic [7:0] MAG_MAX = 8'd255;

endpackage

[design/serial_wheel_command_driver.sv]
// Serial wheel command driver: line parser, message timer, reversal pause and duty mapping.
//
//   channel  signals                         beat
//   in       in_valid, in_stall, in_data     one received byte or one millisecond tick
//   out      out_valid, out_stall, out_data  drive outputs after that beat
//   cfg      cfg_we, cfg_index, cfg_data     one register write, no handshake back
//
// Every input beat is handled in the cycle it is accepted, its output beat buffered; one
// beat per cycle is sustained while out_stall is low. The path that sets the clock is the
// parser into the 8x8 duty multiplier and its reciprocal scaling for the division by 255.
// Output beats sit in a two-entry buffer, so input is stalled only while both entries
// are full. Reset restores register defaults and empties the buffer; no clearing pass.
module serial_wheel_command_driver
	import swcd_pkg::*;
#(
	parameter int LINE_LENGTH = 128,
	parameter int TIMER_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  cmd_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output drv_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LC_W  = $clog2(LINE_LENGTH);
	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [LC_W-1:0] LC_LIMIT = LC_W'(LINE_LENGTH - 1);

	// Configuration registers.
	logic [15:0] timeout_q, rev_pause_q;
	logic [7:0]  marker_q, out_min_q, out_max_q;

	// Parser and drive state.
	logic [7:0]            accum_q, accum_d;
	logic                  minus_q, minus_d;
	phase_t                phase_q, phase_d;
	logic [LC_W-1:0]       line_cnt_q, line_cnt_d;
	logic                  expect_right_q, expect_right_d;
	logic [7:0]            lval_mag_q, lval_mag_d, rval_mag_q, rval_mag_d;
	logic                  lval_neg_q, lval_neg_d, rval_neg_q, rval_neg_d;
	logic                  pending_q, pending_d;
	logic [7:0]            lcmd_mag_q, lcmd_mag_d, rcmd_mag_q, rcmd_mag_d;
	logic                  lcmd_neg_q, lcmd_neg_d, rcmd_neg_q, rcmd_neg_d;
	logic [TIMER_BITS-1:0] since_q, since_d;
	logic [15:0]           pause_q, pause_d;
	logic [7:0]            ldrv_q, ldrv_d, rdrv_q, rdrv_d;
	logic                  lrev_q, lrev_d, rrev_q, rrev_d;

	// Output buffer.
	logic     out_valid_q, skid_valid_q;
	drv_out_t out_q, skid_q;
	drv_out_t result;

	logic       accept, take, alive, is_digit, is_blank, rev;
	logic [3:0] digit;
	logic [11:0] acc_next;
	logic [8:0] lmap, rmap;

	// Maps a magnitude onto lo..hi; returns {reverse, duty}, and zero for a zero magnitude or a zero duty.
	function automatic logic [8:0] map_duty(input logic [7:0] mag, input logic neg,
			input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0]  span;
		logic [15:0] prod;
		logic [30:0] scaled;
		logic [7:0]  q;
		logic [7:0]  duty;
		logic [8:0]  res;
		span   = (hi >= lo) ? (hi - lo) : (lo - hi);
		prod   = {8'b0, mag} * {8'b0, span};
		// Multiplying by 0x8081 and dropping 23 bits is an exact divide by 255 here.
		scaled = {prod, 15'b0} + {8'b0, prod, 7'b0} + {15'b0, prod};
		q      = scaled[30:23];
		duty   = (hi >= lo) ? (lo + q) : (lo - q);
		if (mag == 8'd0 || duty == 8'd0) begin
			res = 9'd0;
		end else begin
			res = {neg, duty};
		end
		return res;
	endfunction

	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !in_stall;
	assign take      = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_digit = (in_data.rx_byte inside {[CHAR_ZERO:CHAR_NINE]});
	assign is_blank = (in_data.rx_byte inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE});
	assign digit    = 4'(in_data.rx_byte - CHAR_ZERO);
	assign acc_next = {4'b0, accum_q} * 12'd10 + {8'b0, digit};

	always_comb begin
		accum_d        = accum_q;
		minus_d        = minus_q;
		phase_d        = phase_q;
		line_cnt_d     = line_cnt_q;
		expect_right_d = expect_right_q;
		lval_mag_d     = lval_mag_q;
		lval_neg_d     = lval_neg_q;
		rval_mag_d     = rval_mag_q;
		rval_neg_d     = rval_neg_q;
		pending_d      = pending_q;
		lcmd_mag_d     = lcmd_mag_q;
		lcmd_neg_d     = lcmd_neg_q;
		rcmd_mag_d     = rcmd_mag_q;
		rcmd_neg_d     = rcmd_neg_q;
		since_d        = since_q;
		pause_d        = pause_q;
		ldrv_d         = ldrv_q;
		rdrv_d         = rdrv_q;
		lrev_d         = lrev_q;
		rrev_d         = rrev_q;

		if (in_data.command == CMD_TICK) begin
			if (since_q != {TIMER_BITS{1'b1}}) begin
				since_d = since_q + 1'b1;
			end
			if (pause_q != 16'd0) begin
				pause_d = pause_q - 16'd1;
			end
		end else if (in_data.rx_byte == marker_q) begin
			if (!expect_right_q) begin
				lval_mag_d     = accum_q;
				lval_neg_d     = minus_q;
				expect_right_d = 1'b1;
			end else begin
				rval_mag_d     = accum_q;
				rval_neg_d     = minus_q;
				expect_right_d = 1'b0;
				pending_d      = 1'b1;
				since_d        = '0;
			end
			accum_d    = 8'd0;
			minus_d    = 1'b0;
			phase_d    = PH_BLANKS;
			line_cnt_d = '0;
		end else if (line_cnt_q < LC_LIMIT) begin
			line_cnt_d = line_cnt_q + 1'b1;
			case (phase_q)
				PH_BLANKS: begin
					if (is_blank) begin
						phase_d = PH_BLANKS;
					end else if (in_data.rx_byte == CHAR_PLUS) begin
						phase_d = PH_SIGNED;
					end else if (in_data.rx_byte == CHAR_MINUS) begin
						minus_d = 1'b1;
						phase_d = PH_SIGNED;
					end else if (is_digit) begin
						accum_d = {4'b0, digit};
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_SIGNED: begin
					if (is_digit) begin
						accum_d = {4'b0, digit};
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						accum_d = (acc_next > 12'(MAG_MAX)) ? MAG_MAX : acc_next[7:0];
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end

		alive = CMP_W'(since_d) < CMP_W'(timeout_q);
		lmap  = map_duty(lval_mag_d, lval_neg_d, out_min_q, out_max_q);
		rmap  = map_duty(rval_mag_d, rval_neg_d, out_min_q, out_max_q);
		// A wheel reverses only when both the new value and the old command are nonzero.
		rev = (lval_mag_d != 8'd0 && lcmd_mag_q != 8'd0 && lval_neg_d != lcmd_neg_q) ||
			(rval_mag_d != 8'd0 && rcmd_mag_q != 8'd0 && rval_neg_d != rcmd_neg_q);

		if (alive && pending_d) begin
			pending_d = 1'b0;
			if (rev) begin
				ldrv_d  = 8'd0;
				rdrv_d  = 8'd0;
				lrev_d  = lval_neg_d && (lval_mag_d != 8'd0);
				rrev_d  = rval_neg_d && (rval_mag_d != 8'd0);
				pause_d = rev_pause_q;
			end
			lcmd_neg_d = lmap[8];
			lcmd_mag_d = lmap[7:0];
			rcmd_neg_d = rmap[8];
			rcmd_mag_d = rmap[7:0];
		end
		if (alive && pause_d == 16'd0) begin
			ldrv_d = lcmd_mag_d;
			rdrv_d = rcmd_mag_d;
			lrev_d = lcmd_neg_d;
			rrev_d = rcmd_neg_d;
		end

		result.left_duty     = ldrv_d;
		result.right_duty    = rdrv_d;
		result.left_reverse  = lrev_d;
		result.right_reverse = rrev_d;
		result.link_alive    = alive;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			rev_pause_q <= REV_PAUSE_RST;
			marker_q    <= END_MARKER_RST;
			out_min_q   <= OUT_MIN_RST;
			out_max_q   <= OUT_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT:    timeout_q   <= cfg_data;
				REG_REV_PAUSE:  rev_pause_q <= cfg_data;
				REG_END_MARKER: marker_q    <= cfg_data[7:0];
				REG_OUT_MIN:    out_min_q   <= cfg_data[7:0];
				REG_OUT_MAX:    out_max_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q        <= 8'd0;
			minus_q        <= 1'b0;
			phase_q        <= PH_BLANKS;
			line_cnt_q     <= '0;
			expect_right_q <= 1'b0;
			lval_mag_q     <= 8'd0;
			lval_neg_q     <= 1'b0;
			rval_mag_q     <= 8'd0;
			rval_neg_q     <= 1'b0;
			pending_q      <= 1'b1;
			lcmd_mag_q     <= 8'd0;
			lcmd_neg_q     <= 1'b0;
			rcmd_mag_q     <= 8'd0;
			rcmd_neg_q     <= 1'b0;
			since_q        <= '0;
			pause_q        <= 16'd0;
			ldrv_q         <= 8'd0;
			rdrv_q         <= 8'd0;
			lrev_q         <= 1'b0;
			rrev_q         <= 1'b0;
		end else if (accept) begin
			accum_q        <= accum_d;
			minus_q        <= minus_d;
			phase_q        <= phase_d;
			line_cnt_q     <= line_cnt_d;
			expect_right_q <= expect_right_d;
			lval_mag_q     <= lval_mag_d;
			lval_neg_q     <= lval_neg_d;
			rval_mag_q     <= rval_mag_d;
			rval_neg_q     <= rval_neg_d;
			pending_q      <= pending_d;
			lcmd_mag_q     <= lcmd_mag_d;
			lcmd_neg_q     <= lcmd_neg_d;
			rcmd_mag_q     <= rcmd_mag_d;
			rcmd_neg_q     <= rcmd_neg_d;
			since_q        <= since_d;
			pause_q        <= pause_d;
			ldrv_q         <= ldrv_d;
			rdrv_q         <= rdrv_d;
			lrev_q         <= lrev_d;
			rrev_q         <= rrev_d;
		end
	end

	// Two-entry output buffer; the second entry fills only while the first is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("second output entry holds a beat while the first is empty");

	a_beat_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid_q)
		else $error("accepted beat left no output beat");

	a_pause_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(pause_q != 16'd0) |-> (ldrv_q == 8'd0 && rdrv_q == 8'd0))
		else $error("duty driven during reversal pause");

	a_pending_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && CMP_W'(since_d) < CMP_W'(timeout_q)) |=> !pending_q)
		else $error("pair left pending while link is alive");

endmodule

[verif/tb.sv]
// Self-checking testbench for the serial wheel command driver.
module tb;
	import swcd_pkg::*;

	localparam int LINE_CAP    = 128;
	localparam int TIMER_MAX   = 65535;
	localparam int PHASE_ITEMS = 230;
	localparam int LONG_HOLD   = 150;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] timeout;
		logic [15:0] pause;
		logic [7:0]  marker;
		logic [7:0]  lo;
		logic [7:0]  hi;
	} setting_t;

	typedef struct packed {
		cmd_in_t  beat;
		logic     typed;
		drv_out_t want;
	} dir_row_t;

	// Register settings walked after the directed part, extremes included.
	localparam setting_t PLAN [6] = '{
		'{16'd120,   16'd40,    8'd13,  8'd30,  8'd200},
		'{16'd40,    16'd0,     8'd10,  8'd0,   8'd255},
		'{16'd1,     16'd3,     8'd59,  8'd255, 8'd0},
		'{16'd65535, 16'd65535, 8'd10,  8'd128, 8'd129},
		'{16'd20,    16'd5,     8'd0,   8'd100, 8'd100},
		'{16'd300,   16'd10,    8'd255, 8'd1,   8'd254}
	};

	localparam drv_out_t STOPPED = '{8'd0, 8'd0, 1'b0, 1'b0, 1'b1};
	localparam drv_out_t UNTYPED = '0;
	localparam drv_out_t FULL_PAIR = '{8'd200, 8'd34, 1'b1, 1'b0, 1'b1};

	// Runs at reset settings: "-300", " \t+7x9", then "5", "-0" which reverses the left wheel.
	localparam dir_row_t DIRECTED [21] = '{
		'{'{CMD_TICK, 8'd0},           1'b1, STOPPED},
		'{'{CMD_BYTE, CHAR_MINUS},     1'b0, UNTYPED},
		'{'{CMD_BYTE, 8'd51},          1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_ZERO},      1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_ZERO},      1'b0, UNTYPED},
		'{'{CMD_BYTE, END_MARKER_RST}, 1'b1, STOPPED},
		'{'{CMD_BYTE, CHAR_SPACE},     1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_TAB},       1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_PLUS},      1'b0, UNTYPED},
		'{'{CMD_BYTE, 8'd55},          1'b0, UNTYPED},
		'{'{CMD_BYTE, 8'd120},         1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_NINE},      1'b0, UNTYPED},
		'{'{CMD_BYTE, END_MARKER_RST}, 1'b1, FULL_PAIR},
		'{'{CMD_BYTE, 8'd53},          1'b0, UNTYPED},
		'{'{CMD_BYTE, END_MARKER_RST}, 1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_MINUS},     1'b0, UNTYPED},
		'{'{CMD_BYTE, CHAR_ZERO},      1'b0, UNTYPED},
		'{'{CMD_BYTE, END_MARKER_RST}, 1'b1, STOPPED},
		'{'{CMD_TICK, 8'hFF},          1'b1, STOPPED},
		'{'{CMD_BYTE, 8'hFF},          1'b0, UNTYPED},
		'{'{CMD_BYTE, 8'h00},          1'b0, UNTYPED}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	cmd_in_t in_data;
	logic out_valid;
	logic out_stall;
	drv_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and the block state.
	int lim_timeout = TIMEOUT_RST;
	int lim_pause   = REV_PAUSE_RST;
	int end_char    = END_MARKER_RST;
	int duty_lo     = OUT_MIN_RST;
	int duty_hi     = OUT_MAX_RST;

	int       digit_acc    = 0;
	bit       minus_seen   = 1'b0;
	phase_t   parse_at     = PH_BLANKS;
	int       line_len     = 0;
	bit       want_right   = 1'b0;
	int       left_val     = 0;
	int       right_val    = 0;
	bit       pair_waiting = 1'b1;
	int       left_cmd     = 0;
	int       right_cmd    = 0;
	int       msg_timer    = 0;
	int       pause_cnt    = 0;
	drv_out_t held         = '0;

	drv_out_t expected_drive [$];
	int items_sent = 0;
	int lines_done = 0;
	int ticks_sent = 0;
	int reversals = 0;
	int link_down_seen = 0;
	int mismatches = 0;
	int stray_results = 0;
	int reports = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	serial_wheel_command_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit opposed(input int a, input int b);
		return (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	// Maps a signed wheel value onto the duty range; zero stays zero.
	function automatic int duty_map(input int raw);
		int mag;
		int duty;
		mag = (raw < 0) ? -raw : raw;
		if (mag == 0)
			return 0;
		duty = mag * (duty_hi - duty_lo) / 255 + duty_lo;
		return (raw < 0) ? -duty : duty;
	endfunction

	// Advances the predicted state by one beat and returns the drive outputs after it.
	function automatic drv_out_t wheel_step(input cmd_in_t b);
		logic [7:0] c;
		bit is_digit;
		bit is_blank;
		bit alive;
		int d;
		int line_val;
		drv_out_t r;
		c = b.rx_byte;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
		d = int'(c) - int'(CHAR_ZERO);
		if (b.command == CMD_TICK) begin
			if (msg_timer < TIMER_MAX)
				msg_timer++;
			if (pause_cnt != 0)
				pause_cnt--;
		end else if (int'(c) == end_char) begin
			line_val = minus_seen ? -digit_acc : digit_acc;
			if (!want_right) begin
				left_val = line_val;
				want_right = 1'b1;
			end else begin
				right_val = line_val;
				want_right = 1'b0;
				pair_waiting = 1'b1;
				msg_timer = 0;
			end
			digit_acc = 0;
			minus_seen = 1'b0;
			parse_at = PH_BLANKS;
			line_len = 0;
			lines_done++;
		end else if (line_len < LINE_CAP - 1) begin
			line_len++;
			case (parse_at)
				PH_BLANKS: begin
					if (c == CHAR_PLUS)
						parse_at = PH_SIGNED;
					else if (c == CHAR_MINUS) begin
						minus_seen = 1'b1;
						parse_at = PH_SIGNED;
					end else if (is_digit) begin
						digit_acc = d;
						parse_at = PH_DIGITS;
					end else if (!is_blank)
						parse_at = PH_DONE;
				end
				PH_SIGNED: begin
					if (is_digit) begin
						digit_acc = d;
						parse_at = PH_DIGITS;
					end else
						parse_at = PH_DONE;
				end
				PH_DIGITS: begin
					if (is_digit) begin
						digit_acc = digit_acc * 10 + d;
						if (digit_acc > 255)
							digit_acc = 255;
					end else
						parse_at = PH_DONE;
				end
				default: ;
			endcase
		end

		alive = (msg_timer < lim_timeout);
		if (alive) begin
			if (pair_waiting) begin
				pair_waiting = 1'b0;
				if (opposed(left_val, left_cmd) || opposed(right_val, right_cmd)) begin
					held.left_duty = 8'd0;
					held.right_duty = 8'd0;
					held.left_reverse = (left_val < 0);
					held.right_reverse = (right_val < 0);
					pause_cnt = lim_pause;
					reversals++;
				end
				left_cmd = duty_map(left_val);
				right_cmd = duty_map(right_val);
			end
			if (pause_cnt == 0) begin
				held.left_reverse = (left_cmd < 0);
				held.right_reverse = (right_cmd < 0);
				held.left_duty = 8'((left_cmd < 0) ? -left_cmd : left_cmd);
				held.right_duty = 8'((right_cmd < 0) ? -right_cmd : right_cmd);
			end
		end
		r = held;
		r.link_alive = alive;
		return r;
	endfunction

	// Offers one beat, waits for it to be taken and queues what it should produce.
	task automatic send_beat(input cmd_in_t b, input logic typed, input drv_out_t want);
		drv_out_t guess;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		guess = wheel_step(b);
		expected_drive.push_back(typed ? want : guess);
		items_sent++;
		if (b.command == CMD_TICK)
			ticks_sent++;
	endtask

	task automatic send_char(input logic [7:0] c);
		send_beat('{CMD_BYTE, c}, 1'b0, UNTYPED);
	endtask

	task automatic send_tick();
		send_beat('{CMD_TICK, 8'($urandom)}, 1'b0, UNTYPED);
	endtask

	// Mostly well-formed value lines with random content, sometimes stray text or an
	// overlong run of blanks whose digit lands either side of the truncation point.
	task automatic send_line();
		int n;
		if ($urandom_range(0, 39) == 0) begin
			repeat ($urandom_range(124, 130)) send_char(CHAR_SPACE);
			send_char(8'd55);
		end else begin
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(0, 3) == 0)
					send_char(CHAR_SPACE);
				else
					send_char(8'(CHAR_TAB + $urandom_range(0, 4)));
			end
			case ($urandom_range(0, 3))
				0, 1: send_char(CHAR_MINUS);
				2: send_char(CHAR_PLUS);
				default: ;
			endcase
			n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			repeat (n) send_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 7) == 0)
				send_char(8'($urandom));
		end
		send_char(8'(end_char));
	endtask

	// Stops offering beats and waits until every queued result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT:    lim_timeout = val;
			REG_REV_PAUSE:  lim_pause = val;
			REG_END_MARKER: end_char = val[7:0];
			REG_OUT_MIN:    duty_lo = val[7:0];
			REG_OUT_MAX:    duty_hi = val[7:0];
			default: ;
		endcase
	endtask

	// Result side: checks every beat taken and stalls in random bursts, plus one long hold.
	initial begin : drive_sink
		drv_out_t want;
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_drive.size() == 0) begin
					stray_results++;
					reports++;
					if (reports <= 10)
						$display("unexpected result beat: %p", out_data);
				end else begin
					want = expected_drive.pop_front();
					if (out_data.left_duty !== want.left_duty ||
							out_data.right_duty !== want.right_duty ||
							out_data.left_reverse !== want.left_reverse ||
							out_data.right_reverse !== want.right_reverse ||
							out_data.link_alive !== want.link_alive) begin
						mismatches++;
						reports++;
						if (reports <= 10)
							$display("mismatch at cycle %0d: got %0d/%0d rev %b%b alive %b, %s %0d/%0d rev %b%b alive %b",
								cycle_count, out_data.left_duty, out_data.right_duty,
								out_data.left_reverse, out_data.right_reverse,
								out_data.link_alive, "expected", want.left_duty,
								want.right_duty, want.left_reverse,
								want.right_reverse, want.link_alive);
					end
					if (!want.link_alive)
						link_down_seen++;
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		setting_t s;
		int burst_cap;
		int pick;
		int phase_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 21; i++)
			send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p < 6; p++) begin
			s = PLAN[p];
			drain();
			write_reg(REG_TIMEOUT, s.timeout);
			write_reg(REG_REV_PAUSE, s.pause);
			write_reg(REG_END_MARKER, {8'd0, s.marker});
			write_reg(REG_OUT_MIN, {8'd0, s.lo});
			write_reg(REG_OUT_MAX, {8'd0, s.hi});
			cfg_we <= 1'b0;
			// Hold the result side off long enough for the output buffer to back up.
			if (p == 1)
				hold_req = 1'b1;
			burst_cap = ((lim_timeout > lim_pause) ? lim_timeout : lim_pause) + 10;
			if (burst_cap > 160)
				burst_cap = 160;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (p == 5 && items_sent - phase_start >= PHASE_ITEMS / 2)
					quiet = 1'b1;
				pick = $urandom_range(0, 19);
				if (pick < 12)
					send_line();
				else if (pick < 16)
					repeat ($urandom_range(1, 3)) send_tick();
				else if (pick < 17)
					repeat ($urandom_range(1, burst_cap)) send_tick();
				else
					send_char(8'($urandom));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d beats: %0d ticks, %0d lines ended, over 6 register settings.",
			items_sent, ticks_sent, lines_done);
		$display("Saw %0d reversal pauses and %0d results with the link down.",
			reversals, link_down_seen);
		if (mismatches == 0 && stray_results == 0 && expected_drive.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
